// ===== rtl/rec_pkg.sv =====
`timescale 1ns / 1ps

package rec_pkg;

    // Sizes of the stored code and the counters
    localparam int DATA_COLS   = 32;
    localparam int PARITY_ROWS = 16;
    localparam int MAX_SYMBOLS = 8;

    // Row store is split into banks so that four rows are read per cycle
    localparam int BANKS       = 4;
    localparam int BANK_DEPTH  = PARITY_ROWS / BANKS;
    localparam int BANK_AW     = $clog2(BANKS);
    localparam int BANK_ADDR_W = $clog2(BANK_DEPTH);
    localparam int ROW_AW      = $clog2(PARITY_ROWS);

    // Full equation: data columns first, then parity columns
    localparam int EQ_W        = DATA_COLS + PARITY_ROWS;

    localparam int COUNT_W     = 17;
    localparam int SLOT_W      = 16;
    localparam int SYM_W       = 3;
    localparam int POS_W       = $clog2(MAX_SYMBOLS);

    // Configuration field widths
    localparam int K_W         = 6;
    localparam int M_W         = 5;
    localparam int W_W         = 4;
    localparam int FD_W        = 6;
    localparam int CFG_DATA_W  = 6;
    localparam int CFG_IDX_W   = 2;

    // Clamped column counts
    localparam int DCNT_W      = $clog2(DATA_COLS + 1);
    localparam int PCNT_W      = $clog2(PARITY_ROWS + 1);
    localparam int BASE_W      = FD_W + W_W;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_EVAL  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DATA_DISKS   = 2'd0,
        CFG_PARITY_DISKS = 2'd1,
        CFG_SYMBOLS      = 2'd2,
        CFG_FAILED_DISK  = 2'd3
    } t_cfg_idx;

    // Controller to datapath commands
    typedef struct packed {
        logic                   capture;
        logic                   load;
        logic                   clear;
        logic                   rd_en;
        logic [BANK_ADDR_W-1:0] rd_addr;
        logic                   win;
        logic                   check;
        logic                   finish;
    } t_ctl;

endpackage

// ===== rtl/rec_ram.sv =====
`timescale 1ns / 1ps

module rec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, read one word with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rec_ctrl.sv =====
`timescale 1ns / 1ps

module rec_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_command,
    output logic          o_busy,
    output logic          o_done,
    output rec_pkg::t_ctl o_ctl
);

    import rec_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_CLEAR,
        S_READ,
        S_DRAIN,
        S_WIN,
        S_CHECK
    } t_state;

    t_state                 r_state, n_state;
    logic [BANK_ADDR_W-1:0] r_cnt, n_cnt;
    logic                   r_busy, r_done;
    logic                   n_done;
    logic                   w_accept;

    assign w_accept = (r_state == S_IDLE) && i_start;

    // Pick the next step of the request
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cnt = '0;
                    case (t_cmd'(i_command))
                        CMD_LOAD: n_state = S_LOAD;
                        CMD_EVAL: n_state = S_READ;
                        default:  n_state = S_CLEAR;
                    endcase
                end
            end
            S_LOAD, S_CLEAR: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
            end
            S_READ: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == BANK_ADDR_W'(BANK_DEPTH - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_WIN;
            S_WIN:   n_state = S_CHECK;
            S_CHECK: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and the handshake outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_busy  <= (n_state != S_IDLE);
            r_done  <= n_done;
        end
    end

    // Decode datapath commands from the state
    always_comb begin
        o_ctl         = '0;
        o_ctl.capture = w_accept;
        o_ctl.load    = (r_state == S_LOAD);
        o_ctl.clear   = (r_state == S_CLEAR);
        o_ctl.rd_en   = (r_state == S_READ);
        o_ctl.rd_addr = r_cnt;
        o_ctl.win     = (r_state == S_WIN);
        o_ctl.check   = (r_state == S_CHECK);
        o_ctl.finish  = (r_state == S_LOAD) || (r_state == S_CLEAR) || (r_state == S_CHECK);
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

// ===== rtl/rec_dp.sv =====
`timescale 1ns / 1ps

module rec_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rec_pkg::t_ctl                   i_ctl,
    input  logic                            i_cfg_we,
    input  logic [rec_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rec_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [1:0]                      i_command,
    input  logic [3:0]                      i_row_index,
    input  logic [31:0]                     i_row_bits,
    input  logic [15:0]                     i_selection,
    output logic [31:0]                     o_data_part,
    output logic [15:0]                     o_parity_part,
    output logic                            o_recoverable,
    output logic [2:0]                      o_symbol,
    output logic [15:0]                     o_group_slot,
    output logic                            o_config_bad
);

    import rec_pkg::*;

    // Configuration registers
    logic [K_W-1:0]  r_k;
    logic [M_W-1:0]  r_m;
    logic [W_W-1:0]  r_w;
    logic [FD_W-1:0] r_fd;

    // Request registers
    t_cmd                   r_cmd;
    logic [ROW_AW-1:0]      r_row_index;
    logic [DATA_COLS-1:0]   r_row_bits;
    logic [PARITY_ROWS-1:0] r_sel;
    logic [DATA_COLS-1:0]   r_data_mask;
    logic [DCNT_W-1:0]      r_data_w;
    logic [BASE_W-1:0]      r_base;
    logic [W_W-1:0]         r_sym_w;
    logic                   r_bad;
    logic [DATA_COLS-1:0]   r_acc;
    logic                   r_fold_vld;
    logic [BANK_ADDR_W-1:0] r_fold_grp;
    logic [MAX_SYMBOLS-1:0] r_win;
    logic [COUNT_W-1:0]     r_counts [MAX_SYMBOLS];

    // Result registers
    logic [DATA_COLS-1:0]   r_data_part;
    logic [PARITY_ROWS-1:0] r_parity_part;
    logic                   r_recoverable;
    logic [SYM_W-1:0]       r_symbol;
    logic [SLOT_W-1:0]      r_group_slot;

    // Configuration derived values
    logic [BASE_W-1:0]      w_kw;
    logic [BASE_W-1:0]      w_mw;
    logic [BASE_W-1:0]      w_base;
    logic [K_W:0]           w_km;
    logic                   w_bad;
    logic [DCNT_W-1:0]      w_data_w;
    logic [PCNT_W-1:0]      w_par_w;
    logic [DATA_COLS-1:0]   w_data_mask;
    logic [PARITY_ROWS-1:0] w_par_mask;

    // Row store read data and fold
    logic [DATA_COLS-1:0]   w_rdata [BANKS];
    logic [DATA_COLS-1:0]   w_fold;
    logic [ROW_AW-1:0]      w_row_idx;

    // Window and check
    logic [EQ_W-1:0]        w_eq;
    logic [EQ_W-1:0]        w_eq_sh;
    logic [MAX_SYMBOLS-1:0] w_win_mask;
    logic                   w_hot;
    logic [POS_W-1:0]       w_pos;
    logic [COUNT_W-1:0]     w_cnt;
    logic                   w_rec;
    logic [SLOT_W-1:0]      w_slot;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k  <= K_W'(4);
            r_m  <= M_W'(2);
            r_w  <= W_W'(4);
            r_fd <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DATA_DISKS:   r_k  <= i_cfg_data[K_W-1:0];
                CFG_PARITY_DISKS: r_m  <= i_cfg_data[M_W-1:0];
                CFG_SYMBOLS:      r_w  <= i_cfg_data[W_W-1:0];
                CFG_FAILED_DISK:  r_fd <= i_cfg_data[FD_W-1:0];
                default: ;
            endcase
        end
    end

    // Check sizes and derive column counts and masks
    always_comb begin
        w_kw   = BASE_W'(r_k) * BASE_W'(r_w);
        w_mw   = BASE_W'(r_m) * BASE_W'(r_w);
        w_base = BASE_W'(r_fd) * BASE_W'(r_w);
        w_km   = {1'b0, r_k} + (K_W + 1)'(r_m);
        w_bad  = (r_k == '0) || (r_m == '0) || (r_w == '0)
              || (w_kw > BASE_W'(DATA_COLS)) || (w_mw > BASE_W'(PARITY_ROWS))
              || (r_w > W_W'(MAX_SYMBOLS)) || ((K_W + 1)'(r_fd) >= w_km);
        w_data_w = (w_kw > BASE_W'(DATA_COLS)) ? DCNT_W'(DATA_COLS) : w_kw[DCNT_W-1:0];
        w_par_w  = (w_mw > BASE_W'(PARITY_ROWS)) ? PCNT_W'(PARITY_ROWS) : w_mw[PCNT_W-1:0];
        for (int c = 0; c < DATA_COLS; c++) begin
            w_data_mask[c] = (DCNT_W'(c) < w_data_w);
        end
        for (int j = 0; j < PARITY_ROWS; j++) begin
            w_par_mask[j] = (PCNT_W'(j) < w_par_w);
        end
    end

    // Row store: row r sits in bank r mod BANKS at address r / BANKS
    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        rec_ram #(
            .WIDTH (DATA_COLS),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (i_ctl.load && (r_row_index[BANK_AW-1:0] == BANK_AW'(b))),
            .i_waddr (r_row_index[ROW_AW-1:BANK_AW]),
            .i_wdata (r_row_bits),
            .i_raddr (i_ctl.rd_addr),
            .o_rdata (w_rdata[b])
        );
    end

    // XOR the selected rows of one read group
    always_comb begin
        w_fold    = '0;
        w_row_idx = '0;
        for (int c = 0; c < BANKS; c++) begin
            w_row_idx = {r_fold_grp, BANK_AW'(c)};
            if (r_sel[w_row_idx]) begin
                w_fold = w_fold ^ w_rdata[c];
            end
        end
    end

    // Cut the failed disk's window out of the full equation
    always_comb begin
        w_eq    = EQ_W'(r_acc & r_data_mask) | (EQ_W'(r_sel) << r_data_w);
        w_eq_sh = w_eq >> r_base;
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            w_win_mask[i] = (W_W'(i) < r_sym_w);
        end
    end

    // Classify the window and look up the symbol's counter
    always_comb begin
        w_hot = (r_win != '0) && ((r_win & (r_win - 1'b1)) == '0);
        w_pos = '0;
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            if (r_win[i]) begin
                w_pos = POS_W'(i);
            end
        end
        w_cnt  = r_counts[w_pos];
        w_rec  = w_hot && !r_bad;
        w_slot = w_cnt[COUNT_W-1] ? {SLOT_W{1'b1}} : w_cnt[SLOT_W-1:0];
    end

    // Control flags of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_vld <= 1'b0;
        end else begin
            r_fold_vld <= i_ctl.rd_en;
        end
    end

    // Capture the request, fold rows, build the window
    always_ff @(posedge i_clk) begin
        r_fold_grp <= i_ctl.rd_addr;
        if (i_ctl.capture) begin
            r_cmd       <= t_cmd'(i_command);
            r_row_index <= i_row_index[ROW_AW-1:0];
            r_row_bits  <= i_row_bits[DATA_COLS-1:0];
            r_sel       <= i_selection[PARITY_ROWS-1:0] & w_par_mask;
            r_data_mask <= w_data_mask;
            r_data_w    <= w_data_w;
            r_base      <= w_base;
            r_sym_w     <= r_w;
            r_bad       <= w_bad;
            r_acc       <= '0;
        end else if (r_fold_vld) begin
            r_acc <= r_acc ^ w_fold;
        end
        if (i_ctl.win) begin
            r_win <= w_eq_sh[MAX_SYMBOLS-1:0] & w_win_mask;
        end
    end

    // Advance or clear the group counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_SYMBOLS; i++) begin
                r_counts[i] <= '0;
            end
        end else if (i_ctl.clear && (r_cmd == CMD_CLEAR)) begin
            for (int i = 0; i < MAX_SYMBOLS; i++) begin
                r_counts[i] <= '0;
            end
        end else if (i_ctl.check && w_rec && (w_cnt != {COUNT_W{1'b1}})) begin
            r_counts[w_pos] <= w_cnt + 1'b1;
        end
    end

    // Load the result registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            r_recoverable <= 1'b0;
            r_symbol      <= '0;
            r_group_slot  <= '0;
            r_data_part   <= '0;
            r_parity_part <= '0;
            if (i_ctl.check) begin
                r_data_part   <= r_acc & r_data_mask;
                r_parity_part <= r_sel;
                r_recoverable <= w_rec;
                r_symbol      <= w_rec ? SYM_W'(w_pos) : '0;
                r_group_slot  <= w_rec ? w_slot : '0;
            end
        end
    end

    assign o_data_part   = r_data_part;
    assign o_parity_part = r_parity_part;
    assign o_recoverable = r_recoverable;
    assign o_symbol      = r_symbol;
    assign o_group_slot  = r_group_slot;
    assign o_config_bad  = r_bad;

endmodule

// ===== rtl/recovery_equation_classifier.sv =====
`timescale 1ns / 1ps

// Recovery equation classifier. A request is taken when start is high and
// busy is low; busy stays high until the result shows on the o_ ports with
// o_done high for exactly one cycle, and the receiver has to take it then.
// An evaluate request reads the sixteen parity rows through four row banks,
// four rows per cycle; then the last fold finishes, the failed disk's window
// is cut out, the window is classified and its group counter updated, and
// the result shows with busy already low.
// o_config_bad reflects the configuration registers at acceptance; write them
// only while busy is low.
module recovery_equation_classifier (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_command,
    input  logic [3:0]                      i_row_index,
    input  logic [31:0]                     i_row_bits,
    input  logic [15:0]                     i_selection,
    input  logic                            i_cfg_we,
    input  logic [rec_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rec_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                            o_done,
    output logic [31:0]                     o_data_part,
    output logic [15:0]                     o_parity_part,
    output logic                            o_recoverable,
    output logic [2:0]                      o_symbol,
    output logic [15:0]                     o_group_slot,
    output logic                            o_config_bad
);

    import rec_pkg::*;

    t_ctl w_ctl;

    rec_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .o_busy    (busy),
        .o_done    (o_done),
        .o_ctl     (w_ctl)
    );

    rec_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_command     (i_command),
        .i_row_index   (i_row_index),
        .i_row_bits    (i_row_bits),
        .i_selection   (i_selection),
        .o_data_part   (o_data_part),
        .o_parity_part (o_parity_part),
        .o_recoverable (o_recoverable),
        .o_symbol      (o_symbol),
        .o_group_slot  (o_group_slot),
        .o_config_bad  (o_config_bad)
    );

endmodule

// ===== rtl/rec_chk.sv =====
`timescale 1ns / 1ps

module rec_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic        o_recoverable,
    input logic [2:0]  o_symbol,
    input logic [15:0] o_group_slot,
    input logic        o_config_bad
);

    // An accepted request keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted request");

    // A result only ends a busy period
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a request in flight");

    // One result per request, never two in a row
    a_single_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    // A bad configuration never reports a recovery
    a_bad_no_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_config_bad) |-> !o_recoverable)
        else $error("recovery reported under a bad configuration");

    // Symbol and slot are zero unless a recovery is reported
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_recoverable) |-> (o_symbol == 3'd0 && o_group_slot == 16'd0))
        else $error("symbol or slot set without a recovery");

endmodule

bind recovery_equation_classifier rec_chk u_rec_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_recoverable (o_recoverable),
    .o_symbol      (o_symbol),
    .o_group_slot  (o_group_slot),
    .o_config_bad  (o_config_bad)
);
